### src/iacb_pkg.sv
// iacb_pkg: word formats, pipeline depths and helpers for the inverse affine clip box core
// no dependencies; imported by inverse_affine_clip_bbox_core and tb_inverse_affine_clip_bbox_core
package iacb_pkg;

  localparam int unsigned WORD_BITS  = 32;
  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned SHIFT_BITS = WORD_BITS - FRAC_BITS;
  localparam int unsigned NUM_LANES  = 4;
  localparam int unsigned PRE_STAGES = 7;
  localparam int unsigned DIV_STAGES = WORD_BITS;
  localparam int unsigned NUM_STAGES = PRE_STAGES + DIV_STAGES + 2;

  // lane order of the four divides
  localparam int unsigned LANE_XLO = 0;
  localparam int unsigned LANE_YLO = 1;
  localparam int unsigned LANE_XHI = 2;
  localparam int unsigned LANE_YHI = 3;

  typedef logic signed [WORD_BITS-1:0]   word_t;
  typedef logic signed [WORD_BITS:0]     diff_t;
  typedef logic signed [2*WORD_BITS:0]   prod_t;
  typedef logic signed [2*WORD_BITS+1:0] num_t;
  typedef logic [2*WORD_BITS:0]          mag_t;
  typedef logic [2*WORD_BITS-1:0]        dmag_t;
  typedef logic [2*WORD_BITS:0]          rem_t;
  typedef logic [WORD_BITS-1:0]          quo_t;

  typedef struct packed {
    rem_t rem;
    quo_t quo;
    quo_t dvd;
    logic neg;
    logic ovf;
  } div_lane_t;

  localparam logic [WORD_BITS:0] LIM_NEG = {2'b01, {(WORD_BITS-1){1'b0}}};
  localparam logic [WORD_BITS:0] LIM_POS = {2'b00, {(WORD_BITS-1){1'b1}}};

  function automatic diff_t sx_diff(word_t x);
    return {x[WORD_BITS-1], x};
  endfunction

endpackage

### src/inverse_affine_clip_bbox_core.sv
// inverse_affine_clip_bbox_core: one request per cycle sustained while the output register
// is not held; depth is set by the four restoring divide pipelines, one quotient bit per
// stage, fed by the determinant and corner products
// the whole pipeline holds while the output register waits; rst_ni clears valid bits only
// depends on iacb_pkg
module inverse_affine_clip_bbox_core (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  iacb_pkg::word_t         mat_a_i,
  input  iacb_pkg::word_t         mat_b_i,
  input  iacb_pkg::word_t         mat_c_i,
  input  iacb_pkg::word_t         mat_d_i,
  input  iacb_pkg::word_t         mat_e_i,
  input  iacb_pkg::word_t         mat_f_i,
  input  iacb_pkg::word_t         clip_x_lo_i,
  input  iacb_pkg::word_t         clip_y_lo_i,
  input  iacb_pkg::word_t         clip_x_hi_i,
  input  iacb_pkg::word_t         clip_y_hi_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output iacb_pkg::word_t         user_x_lo_o,
  output iacb_pkg::word_t         user_y_lo_o,
  output iacb_pkg::word_t         user_x_hi_o,
  output iacb_pkg::word_t         user_y_hi_o,
  output logic                    singular_o
);
  import iacb_pkg::*;

  logic                  adv;
  logic [NUM_STAGES-1:0] v_q, v_d;

  // stage 1: corner offsets
  word_t s1_a_q, s1_b_q, s1_c_q, s1_d_q;
  diff_t s1_dx0_q, s1_dx1_q, s1_dy0_q, s1_dy1_q;
  // stage 2: products
  prod_t s2_ad_q, s2_bc_q;
  prod_t s2_ddx0_q, s2_ddx1_q, s2_cdy0_q, s2_cdy1_q;
  prod_t s2_ady0_q, s2_ady1_q, s2_bdx0_q, s2_bdx1_q;
  prod_t p_ad, p_bc, p_ddx0, p_ddx1, p_cdy0, p_cdy1, p_ady0, p_ady1, p_bdx0, p_bdx1;
  // stage 3: determinant and pairwise extremes
  prod_t s3_det_q;
  prod_t s3_dmin_q, s3_dmax_q, s3_cmin_q, s3_cmax_q;
  prod_t s3_amin_q, s3_amax_q, s3_bmin_q, s3_bmax_q;
  // stage 4: extreme numerators
  num_t  s4_xlo_q, s4_xhi_q, s4_ylo_q, s4_yhi_q;
  num_t  n_xlo, n_xhi, n_ylo, n_yhi;
  prod_t det_abs;
  logic  s4_dneg_q, s4_sing_q;
  dmag_t s4_dabs_q;
  // stage 5: numerators folded onto a positive divisor
  num_t  s5_num_q [NUM_LANES];
  dmag_t s5_dabs_q;
  logic  s5_sing_q;
  // stage 6: magnitude and sign
  mag_t  s6_mag_q [NUM_LANES];
  logic  s6_neg_q [NUM_LANES];
  dmag_t s6_dabs_q;
  logic  s6_sing_q;
  num_t  mag_full [NUM_LANES];
  // divide pipeline, index 0 is the stage 7 setup
  div_lane_t dv_q [DIV_STAGES+1][NUM_LANES];
  div_lane_t dv_d [DIV_STAGES][NUM_LANES];
  dmag_t     dd_q [DIV_STAGES+1];
  logic      ds_q [DIV_STAGES+1];
  div_lane_t setup_d [NUM_LANES];
  // finish stages
  quo_t      f1_mag_q [NUM_LANES];
  logic      f1_neg_q [NUM_LANES];
  logic      f1_sing_q;
  quo_t      f1_mag_d [NUM_LANES];
  word_t     out_q [NUM_LANES];
  logic      out_sing_q;
  word_t     out_d [NUM_LANES];

  assign adv        = !v_q[NUM_STAGES-1] || out_ready_i;
  assign in_ready_o = adv;
  assign v_d        = {v_q[NUM_STAGES-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= v_d;
    end
  end

  assign p_ad   = s1_a_q * s1_d_q;
  assign p_bc   = s1_b_q * s1_c_q;
  assign p_ddx0 = s1_d_q * s1_dx0_q;
  assign p_ddx1 = s1_d_q * s1_dx1_q;
  assign p_cdy0 = s1_c_q * s1_dy0_q;
  assign p_cdy1 = s1_c_q * s1_dy1_q;
  assign p_ady0 = s1_a_q * s1_dy0_q;
  assign p_ady1 = s1_a_q * s1_dy1_q;
  assign p_bdx0 = s1_b_q * s1_dx0_q;
  assign p_bdx1 = s1_b_q * s1_dx1_q;

  assign n_xlo   = s3_dmin_q - s3_cmax_q;
  assign n_xhi   = s3_dmax_q - s3_cmin_q;
  assign n_ylo   = s3_amin_q - s3_bmax_q;
  assign n_yhi   = s3_amax_q - s3_bmin_q;
  assign det_abs = s3_det_q[2*WORD_BITS] ? -s3_det_q : s3_det_q;

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      mag_full[l]        = s5_num_q[l][2*WORD_BITS+1] ? -s5_num_q[l] : s5_num_q[l];
      setup_d[l].neg     = s6_neg_q[l];
      setup_d[l].ovf     = (s6_mag_q[l] >> SHIFT_BITS) >= {1'b0, s6_dabs_q};
      setup_d[l].rem     = s6_mag_q[l] >> SHIFT_BITS;
      setup_d[l].dvd     = {s6_mag_q[l][SHIFT_BITS-1:0], {FRAC_BITS{1'b0}}};
      setup_d[l].quo     = '0;
    end
  end

  always_comb begin
    logic [2*WORD_BITS:0] sh;
    logic                 ge;
    for (int s = 0; s < DIV_STAGES; s++) begin
      for (int l = 0; l < NUM_LANES; l++) begin
        sh = {dv_q[s][l].rem[2*WORD_BITS-1:0], dv_q[s][l].dvd[WORD_BITS-1]};
        ge = sh >= {1'b0, dd_q[s]};
        dv_d[s][l].rem = ge ? sh - {1'b0, dd_q[s]} : sh;
        dv_d[s][l].quo = {dv_q[s][l].quo[WORD_BITS-2:0], ge};
        dv_d[s][l].dvd = {dv_q[s][l].dvd[WORD_BITS-2:0], 1'b0};
        dv_d[s][l].neg = dv_q[s][l].neg;
        dv_d[s][l].ovf = dv_q[s][l].ovf;
      end
    end
  end

  always_comb begin
    logic [WORD_BITS:0] q1;
    logic [WORD_BITS:0] lim;
    logic               inc;
    for (int l = 0; l < NUM_LANES; l++) begin
      inc = dv_q[DIV_STAGES][l].neg && (dv_q[DIV_STAGES][l].rem != '0);
      q1  = {1'b0, dv_q[DIV_STAGES][l].quo} + {{WORD_BITS{1'b0}}, inc};
      lim = dv_q[DIV_STAGES][l].neg ? LIM_NEG : LIM_POS;
      if (dv_q[DIV_STAGES][l].ovf || (q1 > lim)) begin
        f1_mag_d[l] = lim[WORD_BITS-1:0];
      end else begin
        f1_mag_d[l] = q1[WORD_BITS-1:0];
      end
      if (f1_sing_q) begin
        out_d[l] = '0;
      end else if (f1_neg_q[l]) begin
        out_d[l] = -f1_mag_q[l];
      end else begin
        out_d[l] = f1_mag_q[l];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_a_q   <= mat_a_i;
      s1_b_q   <= mat_b_i;
      s1_c_q   <= mat_c_i;
      s1_d_q   <= mat_d_i;
      s1_dx0_q <= sx_diff(clip_x_lo_i) - sx_diff(mat_e_i);
      s1_dx1_q <= sx_diff(clip_x_hi_i) - sx_diff(mat_e_i);
      s1_dy0_q <= sx_diff(clip_y_lo_i) - sx_diff(mat_f_i);
      s1_dy1_q <= sx_diff(clip_y_hi_i) - sx_diff(mat_f_i);

      s2_ad_q   <= p_ad;
      s2_bc_q   <= p_bc;
      s2_ddx0_q <= p_ddx0;
      s2_ddx1_q <= p_ddx1;
      s2_cdy0_q <= p_cdy0;
      s2_cdy1_q <= p_cdy1;
      s2_ady0_q <= p_ady0;
      s2_ady1_q <= p_ady1;
      s2_bdx0_q <= p_bdx0;
      s2_bdx1_q <= p_bdx1;

      s3_det_q  <= s2_ad_q - s2_bc_q;
      s3_dmin_q <= (s2_ddx0_q < s2_ddx1_q) ? s2_ddx0_q : s2_ddx1_q;
      s3_dmax_q <= (s2_ddx0_q < s2_ddx1_q) ? s2_ddx1_q : s2_ddx0_q;
      s3_cmin_q <= (s2_cdy0_q < s2_cdy1_q) ? s2_cdy0_q : s2_cdy1_q;
      s3_cmax_q <= (s2_cdy0_q < s2_cdy1_q) ? s2_cdy1_q : s2_cdy0_q;
      s3_amin_q <= (s2_ady0_q < s2_ady1_q) ? s2_ady0_q : s2_ady1_q;
      s3_amax_q <= (s2_ady0_q < s2_ady1_q) ? s2_ady1_q : s2_ady0_q;
      s3_bmin_q <= (s2_bdx0_q < s2_bdx1_q) ? s2_bdx0_q : s2_bdx1_q;
      s3_bmax_q <= (s2_bdx0_q < s2_bdx1_q) ? s2_bdx1_q : s2_bdx0_q;

      s4_xlo_q  <= n_xlo;
      s4_xhi_q  <= n_xhi;
      s4_ylo_q  <= n_ylo;
      s4_yhi_q  <= n_yhi;
      s4_dneg_q <= s3_det_q[2*WORD_BITS];
      s4_sing_q <= (s3_det_q == '0);
      s4_dabs_q <= det_abs[2*WORD_BITS-1:0];

      // negative divisor swaps which numerator gives the minimum
      s5_num_q[LANE_XLO] <= s4_dneg_q ? -s4_xhi_q : s4_xlo_q;
      s5_num_q[LANE_XHI] <= s4_dneg_q ? -s4_xlo_q : s4_xhi_q;
      s5_num_q[LANE_YLO] <= s4_dneg_q ? -s4_yhi_q : s4_ylo_q;
      s5_num_q[LANE_YHI] <= s4_dneg_q ? -s4_ylo_q : s4_yhi_q;
      s5_dabs_q <= s4_dabs_q;
      s5_sing_q <= s4_sing_q;

      for (int l = 0; l < NUM_LANES; l++) begin
        s6_mag_q[l] <= mag_full[l][2*WORD_BITS:0];
        s6_neg_q[l] <= s5_num_q[l][2*WORD_BITS+1];
        dv_q[0][l]  <= setup_d[l];
      end
      s6_dabs_q <= s5_dabs_q;
      s6_sing_q <= s5_sing_q;
      dd_q[0]   <= s6_dabs_q;
      ds_q[0]   <= s6_sing_q;

      for (int s = 0; s < DIV_STAGES; s++) begin
        for (int l = 0; l < NUM_LANES; l++) begin
          dv_q[s+1][l] <= dv_d[s][l];
        end
        dd_q[s+1] <= dd_q[s];
        ds_q[s+1] <= ds_q[s];
      end

      for (int l = 0; l < NUM_LANES; l++) begin
        f1_mag_q[l] <= f1_mag_d[l];
        f1_neg_q[l] <= dv_q[DIV_STAGES][l].neg;
        out_q[l]    <= out_d[l];
      end
      f1_sing_q  <= ds_q[DIV_STAGES];
      out_sing_q <= f1_sing_q;
    end
  end

  assign out_valid_o = v_q[NUM_STAGES-1];
  assign user_x_lo_o = out_q[LANE_XLO];
  assign user_y_lo_o = out_q[LANE_YLO];
  assign user_x_hi_o = out_q[LANE_XHI];
  assign user_y_hi_o = out_q[LANE_YHI];
  assign singular_o  = out_sing_q;

  a_sing_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && singular_o |-> user_x_lo_o == '0 && user_y_lo_o == '0 &&
                                  user_x_hi_o == '0 && user_y_hi_o == '0)
    else $error("singular result with non-zero box");

  a_box_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> user_x_lo_o <= user_x_hi_o && user_y_lo_o <= user_y_hi_o)
    else $error("box minimum above maximum");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(v_q))
    else $error("pipeline moved during stall");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> v_q[0])
    else $error("accepted request missing from first stage");

endmodule

### sim/tb_inverse_affine_clip_bbox_core.sv
// tb_inverse_affine_clip_bbox_core: self-checking bench for the inverse affine clip box core
// directed and random requests, bursty sender, stalling receiver, bit-exact box predictor
// depends on iacb_pkg and inverse_affine_clip_bbox_core
module tb_inverse_affine_clip_bbox_core;
  import iacb_pkg::*;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    word_t a, b, c, d, e, f, xlo, ylo, xhi, yhi;
  } xform_req_t;

  typedef struct {
    word_t xlo, ylo, xhi, yhi;
    logic  sing;
  } user_box_t;

  localparam word_t WMAX = 32'sh7fffffff;
  localparam word_t WMIN = 32'sh80000000;
  localparam word_t ONE  = 32'sh00010000;
  localparam int    LONG_HOLD = 200;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic out_ready_i = 1'b0;
  word_t mat_a_i = '0, mat_b_i = '0, mat_c_i = '0, mat_d_i = '0, mat_e_i = '0, mat_f_i = '0;
  word_t clip_x_lo_i = '0, clip_y_lo_i = '0, clip_x_hi_i = '0, clip_y_hi_i = '0;
  logic in_ready_o, out_valid_o, singular_o;
  word_t user_x_lo_o, user_y_lo_o, user_x_hi_o, user_y_hi_o;

  xform_req_t req_q[$];
  user_box_t  box_q[$];
  logic in_fire = 1'b0;
  int errors = 0;
  int sent = 0;
  int checked = 0;
  int singular_seen = 0;
  int burst_left = 0;
  int gap_left = 0;
  bit drain_pause = 1'b0;
  bit drain_done = 1'b0;
  int cycle = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int stall_mode = 0;

  inverse_affine_clip_bbox_core u_top (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic word_t floor_div_sat(wide_t num, wide_t det);
    logic neg;
    logic [127:0] n, dd, q, r, lim;
    neg = num[127] ^ det[127];
    n = num[127] ? -num : num;
    dd = det[127] ? -det : det;
    n = n << FRAC_BITS;
    q = n / dd;
    r = n % dd;
    if (neg && r != 0) q = q + 1;
    lim = neg ? 128'h80000000 : 128'h7fffffff;
    if (q > lim) q = lim;
    return neg ? word_t'(-q[31:0]) : word_t'(q[31:0]);
  endfunction

  function automatic user_box_t predict_box(xform_req_t t);
    user_box_t bx;
    wide_t det, dx, dy;
    word_t ux, uy;
    det = wide_t'(t.a) * wide_t'(t.d) - wide_t'(t.b) * wide_t'(t.c);
    bx = '{default: '0};
    if (det == 0) begin
      bx.sing = 1'b1;
      return bx;
    end
    for (int k = 0; k < 4; k++) begin
      dx = wide_t'(k[0] ? t.xhi : t.xlo) - wide_t'(t.e);
      dy = wide_t'(k[1] ? t.yhi : t.ylo) - wide_t'(t.f);
      ux = floor_div_sat(wide_t'(t.d) * dx - wide_t'(t.c) * dy, det);
      uy = floor_div_sat(wide_t'(t.a) * dy - wide_t'(t.b) * dx, det);
      if (k == 0 || ux < bx.xlo) bx.xlo = ux;
      if (k == 0 || ux > bx.xhi) bx.xhi = ux;
      if (k == 0 || uy < bx.ylo) bx.ylo = uy;
      if (k == 0 || uy > bx.yhi) bx.yhi = uy;
    end
    return bx;
  endfunction

  task automatic report_mismatch(string what, word_t got, word_t want);
    $display("mismatch %s at result %0d: got %h want %h", what, checked, got, want);
    errors++;
  endtask

  function automatic word_t rand_word(int mode);
    case (mode)
      0: return word_t'($urandom);
      1: return word_t'($signed($urandom_range(0, 8 * ONE)) - 4 * ONE);
      2: return word_t'($signed($urandom_range(0, 2000)) - 1000);
      default: return ($urandom_range(0, 1)) ? WMAX : WMIN;
    endcase
  endfunction

  task automatic add_req(word_t a, word_t b, word_t c, word_t d, word_t e, word_t f,
                         word_t x0, word_t y0, word_t x1, word_t y1);
    xform_req_t t;
    t = '{a, b, c, d, e, f, x0, y0, x1, y1};
    req_q.push_back(t);
  endtask

  task automatic add_random_req();
    int m, mr;
    xform_req_t t;
    m = $urandom_range(0, 9);
    mr = (m < 2) ? 0 : (m < 8) ? 1 : (m < 9) ? 2 : 3;
    t.a = rand_word(mr); t.b = rand_word(mr); t.c = rand_word(mr); t.d = rand_word(mr);
    if ($urandom_range(0, 2) == 0) begin
      t.b = rand_word(2); t.c = rand_word(2);
    end
    if ($urandom_range(0, 11) == 0) begin
      t.c = t.a; t.d = t.b;
    end
    mr = ($urandom_range(0, 3) == 0) ? 0 : 1;
    t.e = rand_word(mr); t.f = rand_word(mr);
    t.xlo = rand_word(mr); t.ylo = rand_word(mr);
    t.xhi = rand_word(mr); t.yhi = rand_word(mr);
    if ($urandom_range(0, 9) == 0) t.xlo = rand_word(3);
    if ($urandom_range(0, 9) == 0) t.yhi = rand_word(3);
    req_q.push_back(t);
  endtask

  initial begin
    add_req(ONE, 0, 0, ONE, 0, 0, -ONE, -ONE, ONE, ONE);
    add_req(ONE, 0, 0, ONE, 5 * ONE, -3 * ONE, 0, 0, 10 * ONE, 4 * ONE);
    add_req(0, 0, 0, 0, 0, 0, ONE, ONE, 2 * ONE, 2 * ONE);
    add_req(ONE, ONE, ONE, ONE, 0, 0, 0, 0, ONE, ONE);
    add_req(WMIN, WMIN, WMIN, WMIN, 0, 0, WMIN, WMIN, WMAX, WMAX);
    add_req(2 * ONE, 0, 0, 3 * ONE, ONE, ONE, 4 * ONE, 4 * ONE, -4 * ONE, -4 * ONE);
    add_req(0, ONE, -ONE, 0, 0, 0, -2 * ONE, -3 * ONE, 5 * ONE, 7 * ONE);
    add_req(-ONE, 0, 0, ONE, 0, 0, ONE, 2 * ONE, 3 * ONE, 4 * ONE);
    add_req(1, 0, 0, 1, 0, 0, WMIN, WMIN, WMAX, WMAX);
    add_req(WMAX, 0, 0, WMAX, 0, 0, WMIN, WMIN, WMAX, WMAX);
    add_req(WMIN, 0, 0, WMAX, WMAX, WMIN, WMIN, WMAX, WMAX, WMIN);
    add_req(WMAX, WMIN, WMAX, WMAX, WMIN, WMAX, WMAX, WMIN, WMIN, WMAX);
    add_req(3, 1, 1, 3, 1, -1, 7, 7, -7, 7);
    add_req(ONE, 0, 0, ONE, WMAX, WMIN, WMIN, WMAX, WMIN, WMAX);
    add_req(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1);
    add_req(ONE / 2, ONE / 3, -ONE / 5, ONE, 7, -9, -100, 100, 100, -100);
    for (int i = 0; i < 535; i++) add_random_req();
  end

  // acceptance, prediction and result checks
  always @(posedge clk_i) begin
    user_box_t want;
    cycle <= cycle + 1;
    in_fire <= in_valid_i && in_ready_o;
    if (in_valid_i && in_ready_o) begin
      box_q.push_back(predict_box('{mat_a_i, mat_b_i, mat_c_i, mat_d_i, mat_e_i, mat_f_i,
                                    clip_x_lo_i, clip_y_lo_i, clip_x_hi_i, clip_y_hi_i}));
    end
    if (out_valid_o && out_ready_i) begin
      if (box_q.size() == 0) begin
        $display("unexpected result at cycle %0d", cycle);
        errors++;
      end else begin
        want = box_q.pop_front();
        if (singular_o !== want.sing) begin
          report_mismatch("singular", word_t'(singular_o), word_t'(want.sing));
        end
        if (user_x_lo_o !== want.xlo) report_mismatch("user_x_lo", user_x_lo_o, want.xlo);
        if (user_y_lo_o !== want.ylo) report_mismatch("user_y_lo", user_y_lo_o, want.ylo);
        if (user_x_hi_o !== want.xhi) report_mismatch("user_x_hi", user_x_hi_o, want.xhi);
        if (user_y_hi_o !== want.yhi) report_mismatch("user_y_hi", user_y_hi_o, want.yhi);
        if (want.sing) singular_seen++;
        checked++;
      end
    end
  end

  // request driver
  always @(negedge clk_i) begin
    xform_req_t t;
    if (rst_ni && (!in_valid_i || in_fire)) begin
      if (sent == 300 && !drain_done) drain_pause = 1'b1;
      if (drain_pause && box_q.size() == 0) begin
        drain_pause = 1'b0;
        drain_done = 1'b1;
      end
      if (gap_left > 0 || drain_pause || req_q.size() == 0) begin
        if (gap_left > 0) gap_left--;
        in_valid_i <= 1'b0;
      end else begin
        t = req_q.pop_front();
        {mat_a_i, mat_b_i, mat_c_i, mat_d_i, mat_e_i} <= {t.a, t.b, t.c, t.d, t.e};
        {mat_f_i, clip_x_lo_i, clip_y_lo_i} <= {t.f, t.xlo, t.ylo};
        {clip_x_hi_i, clip_y_hi_i} <= {t.xhi, t.yhi};
        in_valid_i <= 1'b1;
        sent++;
        if (burst_left > 0) burst_left--;
        else begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
  end

  // result receiver with its own stall pattern
  always @(negedge clk_i) begin
    if (cycle % 64 == 0) stall_mode = $urandom_range(0, 2);
    if (sent >= 80 && !hold_done) begin
      hold_left = LONG_HOLD;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      case (stall_mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= ($urandom_range(0, 1) == 1);
        default: out_ready_i <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;
    wait (req_q.size() == 0 && !in_valid_i && box_q.size() == 0);
    repeat (60) @(posedge clk_i);
    $display("requests sent %0d, results checked %0d, singular results %0d, errors %0d",
             sent, checked, singular_seen, errors);
    $display("covered extreme words, singular and swapped rectangles, saturation, stalls");
    if (errors == 0 && box_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout with %0d results outstanding", box_q.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

### filelist.f
src/iacb_pkg.sv
src/inverse_affine_clip_bbox_core.sv
sim/tb_inverse_affine_clip_bbox_core.sv
